FILE: src/bfd_pkg.sv
// Shared constants, codes and types of the bounded FIFO with duplicate suppression.
package bfd_pkg;

    localparam int QUEUE_DEPTH_DEF = 256;
    localparam int TAG_BITS_DEF    = 16;

    localparam int KEY_BITS    = 64;
    localparam int CAP_BITS    = 9;
    localparam int SIZE_BITS   = 8;
    localparam int OCC_BITS    = 9;
    localparam int STATUS_BITS = 3;
    localparam int REQ_BITS    = 2;
    localparam int S_USER_BITS = REQ_BITS + 1;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 9'd256;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_CAPACITY_LIMIT = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEDUP_ENABLE   = 1'b1;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_PUSH    = 2'd0,
        REQ_POP     = 2'd1,
        REQ_STOP    = 2'd2,
        REQ_RESTART = 2'd3
    } req_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_QUEUED  = 3'd0,
        STATUS_DUP     = 3'd1,
        STATUS_FULL    = 3'd2,
        STATUS_POPPED  = 3'd3,
        STATUS_EMPTY   = 3'd4,
        STATUS_SHUT    = 3'd5,
        STATUS_CLEARED = 3'd6
    } status_t;

    // Commands from the sequencer to the dedup table.
    typedef struct packed {
        logic wr;     // write key and marker at the index and mark it valid
        logic drop;   // mark the entry at the index invalid
        logic flush;  // mark every entry invalid
    } tbl_cmd_t;

endpackage

FILE: src/bfd_dedup_table.sv
// Dedup table: key and marker memory with one registered read port and per-entry valid bits.
module bfd_dedup_table #(
    parameter int DEPTH = bfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [$clog2(DEPTH)-1:0]      rd_idx,
    input  bfd_pkg::tbl_cmd_t             cmd,
    input  logic [$clog2(DEPTH)-1:0]      wr_idx,
    input  logic [bfd_pkg::KEY_BITS-1:0]  wr_key,
    input  logic [bfd_pkg::KEY_BITS-1:0]  wr_marker,
    output logic                          rd_valid,
    output logic [bfd_pkg::KEY_BITS-1:0]  rd_key,
    output logic [bfd_pkg::KEY_BITS-1:0]  rd_marker
);

    localparam int EW = 2 * bfd_pkg::KEY_BITS;

    logic [EW-1:0]    mem [DEPTH];
    logic [EW-1:0]    rd_data_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[wr_idx] <= {wr_marker, wr_key};
        end
        rd_data_reg <= mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_idx];
            if (cmd.flush)
            begin
                valid_reg <= '0;
            end
            else if (cmd.wr)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            else if (cmd.drop)
            begin
                valid_reg[wr_idx] <= 1'b0;
            end
        end
    end

    assign rd_valid  = rd_valid_reg;
    assign rd_key    = rd_data_reg[bfd_pkg::KEY_BITS-1:0];
    assign rd_marker = rd_data_reg[EW-1:bfd_pkg::KEY_BITS];

endmodule

FILE: src/bounded_fifo_with_dedup_core.sv
// Top level: bounded request FIFO with hash-based duplicate suppression.
//
// Each request (push, pop, stop or restart) returns exactly one result with a status,
// the popped tag and insert size, and the occupancy after the request. The block takes
// one request at a time: s_tready is high only while the sequencer is idle, and a finished
// result sits in the output register so the next request can be taken while it waits.
// A push that is rejected, a push without dedup, a pop without a hash to remove, and stop
// or restart finish in the execution state without a table walk. A push with dedup on, or a
// pop of a hashed entry with dedup on, walks the dedup table through its single registered
// read port, one entry per cycle, over at most QUEUE_DEPTH entries; the walk ends early on
// the first valid entry that holds the same hash. The table's
// valid bits are flip-flops that clear at once, so no clearing pass follows reset, stop or
// restart. The effective capacity is the smaller of capacity_limit and QUEUE_DEPTH, and the
// insert size of a queued request keeps the low 8 bits of the occupancy at insert time.
module bounded_fifo_with_dedup_core #(
    parameter int QUEUE_DEPTH = bfd_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = bfd_pkg::TAG_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write port.
    input  logic                                  cfg_we,
    input  logic [bfd_pkg::CFG_IDX_BITS-1:0]      cfg_idx,
    input  logic [bfd_pkg::CAP_BITS-1:0]          cfg_wdata,
    // Request stream.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0 up: item_tag, hash_key, unique_marker, zero padding.
    input  logic [((TAG_BITS+2*bfd_pkg::KEY_BITS+7)/8)*8-1:0] s_tdata,
    // Fields from bit 0 up: req_type, has_hash.
    input  logic [bfd_pkg::S_USER_BITS-1:0]       s_tuser,
    // Result stream.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // Fields from bit 0 up: out_tag, size_at_insert, occupancy, zero padding.
    output logic [((TAG_BITS+bfd_pkg::SIZE_BITS+bfd_pkg::OCC_BITS+7)/8)*8-1:0] m_tdata,
    // Fields from bit 0 up: status.
    output logic [bfd_pkg::STATUS_BITS-1:0]       m_tuser
);

    localparam int KB  = bfd_pkg::KEY_BITS;
    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int SPW = AW + 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int LW  = (CW > bfd_pkg::CAP_BITS) ? CW : bfd_pkg::CAP_BITS;
    localparam int FW  = TAG_BITS + KB + 1 + bfd_pkg::SIZE_BITS;
    localparam int MDW = ((TAG_BITS + bfd_pkg::SIZE_BITS + bfd_pkg::OCC_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t                         state_reg;
    bfd_pkg::req_t                  req_reg;
    logic [TAG_BITS-1:0]            tag_reg;
    logic                           has_hash_reg;
    logic [KB-1:0]                  key_reg;
    logic [KB-1:0]                  marker_reg;

    logic [bfd_pkg::CAP_BITS-1:0]   cap_reg;
    logic                           dedup_en_reg;

    logic [AW-1:0]                  head_reg;
    logic [AW-1:0]                  tail_reg;
    logic [CW-1:0]                  count_reg;
    logic                           shut_reg;

    logic [SPW-1:0]                 scan_ptr_reg;
    logic                           cmp_valid_reg;
    logic [AW-1:0]                  cmp_idx_reg;
    logic                           free_found_reg;
    logic [AW-1:0]                  free_idx_reg;

    bfd_pkg::status_t               res_status_reg;
    logic [TAG_BITS-1:0]            res_tag_reg;
    logic [bfd_pkg::SIZE_BITS-1:0]  res_size_reg;

    logic                           m_tvalid_reg;
    bfd_pkg::status_t               out_status_reg;
    logic [TAG_BITS-1:0]            out_tag_reg;
    logic [bfd_pkg::SIZE_BITS-1:0]  out_size_reg;
    logic [bfd_pkg::OCC_BITS-1:0]   out_occ_reg;

    // Queue storage: one word per slot holding tag, hash, hash flag and insert size.
    logic [FW-1:0]                  fifo_mem [QUEUE_DEPTH];
    logic [FW-1:0]                  fifo_rd_reg;

    logic [TAG_BITS-1:0]            rd_tag;
    logic [KB-1:0]                  rd_hash;
    logic                           rd_hash_valid;
    logic [bfd_pkg::SIZE_BITS-1:0]  rd_size;

    logic                           tbl_rd_valid;
    logic [KB-1:0]                  tbl_rd_key;
    logic [KB-1:0]                  tbl_rd_marker;
    bfd_pkg::tbl_cmd_t              tbl_cmd;
    logic [AW-1:0]                  tbl_wr_idx;

    logic                           out_free;
    logic                           cap_hit;
    logic                           pop_ok;
    logic                           scan_issue;
    logic                           scan_hit;
    logic                           marker_eq;
    logic                           scan_last;
    logic                           enq;
    logic                           deq;
    logic                           start_scan;
    logic                           fin;
    bfd_pkg::status_t               fin_status;

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    assign rd_tag        = fifo_rd_reg[TAG_BITS-1:0];
    assign rd_hash       = fifo_rd_reg[TAG_BITS +: KB];
    assign rd_hash_valid = fifo_rd_reg[TAG_BITS + KB];
    assign rd_size       = fifo_rd_reg[TAG_BITS + KB + 1 +: bfd_pkg::SIZE_BITS];

    // The queue is full at the smaller of the programmed limit and the physical depth.
    assign cap_hit = (LW'(count_reg) >= LW'(cap_reg)) || (count_reg == CW'(QUEUE_DEPTH));
    assign pop_ok  = !shut_reg && (count_reg != '0);

    assign scan_issue = scan_ptr_reg < SPW'(QUEUE_DEPTH);
    assign scan_hit   = tbl_rd_valid && (tbl_rd_key == key_reg);
    assign marker_eq  = (tbl_rd_marker == marker_reg);
    assign scan_last  = (cmp_idx_reg == AW'(QUEUE_DEPTH - 1));

    // Sequencer decisions for the current cycle.
    always_comb
    begin
        enq        = 1'b0;
        deq        = 1'b0;
        start_scan = 1'b0;
        fin        = 1'b0;
        fin_status = bfd_pkg::STATUS_QUEUED;
        tbl_cmd    = '0;
        tbl_wr_idx = cmp_idx_reg;
        unique case (state_reg)
            ST_EXEC:
            begin
                unique case (req_reg) inside
                    bfd_pkg::REQ_PUSH:
                    begin
                        if (cap_hit)
                        begin
                            fin        = 1'b1;
                            fin_status = bfd_pkg::STATUS_FULL;
                        end
                        else if (dedup_en_reg && has_hash_reg)
                        begin
                            start_scan = 1'b1;
                        end
                        else
                        begin
                            enq        = 1'b1;
                            fin        = 1'b1;
                            fin_status = bfd_pkg::STATUS_QUEUED;
                        end
                    end
                    bfd_pkg::REQ_POP:
                    begin
                        if (shut_reg)
                        begin
                            fin        = 1'b1;
                            fin_status = bfd_pkg::STATUS_SHUT;
                        end
                        else if (count_reg == '0)
                        begin
                            fin        = 1'b1;
                            fin_status = bfd_pkg::STATUS_EMPTY;
                        end
                        else if (dedup_en_reg && rd_hash_valid)
                        begin
                            start_scan = 1'b1;
                        end
                        else
                        begin
                            deq        = 1'b1;
                            fin        = 1'b1;
                            fin_status = bfd_pkg::STATUS_POPPED;
                        end
                    end
                    bfd_pkg::REQ_STOP, bfd_pkg::REQ_RESTART:
                    begin
                        tbl_cmd.flush = 1'b1;
                        fin           = 1'b1;
                        fin_status    = bfd_pkg::STATUS_CLEARED;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (cmp_valid_reg)
                begin
                    if (scan_hit)
                    begin
                        fin = 1'b1;
                        if (req_reg == bfd_pkg::REQ_PUSH)
                        begin
                            if (marker_eq)
                            begin
                                fin_status = bfd_pkg::STATUS_DUP;
                            end
                            else
                            begin
                                tbl_cmd.wr = 1'b1;
                                enq        = 1'b1;
                                fin_status = bfd_pkg::STATUS_QUEUED;
                            end
                        end
                        else
                        begin
                            tbl_cmd.drop = 1'b1;
                            deq          = 1'b1;
                            fin_status   = bfd_pkg::STATUS_POPPED;
                        end
                    end
                    else if (scan_last)
                    begin
                        fin = 1'b1;
                        if (req_reg == bfd_pkg::REQ_PUSH)
                        begin
                            // A new hash takes the first free slot; with none left it is
                            // simply not recorded.
                            tbl_cmd.wr = free_found_reg || !tbl_rd_valid;
                            tbl_wr_idx = free_found_reg ? free_idx_reg : cmp_idx_reg;
                            enq        = 1'b1;
                            fin_status = bfd_pkg::STATUS_QUEUED;
                        end
                        else
                        begin
                            deq        = 1'b1;
                            fin_status = bfd_pkg::STATUS_POPPED;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer state, queue pointers, configuration and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            req_reg        <= bfd_pkg::REQ_PUSH;
            tag_reg        <= '0;
            has_hash_reg   <= 1'b0;
            key_reg        <= '0;
            marker_reg     <= '0;
            cap_reg        <= bfd_pkg::CAP_RESET;
            dedup_en_reg   <= 1'b1;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            shut_reg       <= 1'b0;
            scan_ptr_reg   <= '0;
            cmp_valid_reg  <= 1'b0;
            cmp_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            res_status_reg <= bfd_pkg::STATUS_QUEUED;
            res_tag_reg    <= '0;
            res_size_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
            out_status_reg <= bfd_pkg::STATUS_QUEUED;
            out_tag_reg    <= '0;
            out_size_reg   <= '0;
            out_occ_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    bfd_pkg::CFG_CAPACITY_LIMIT: cap_reg      <= cfg_wdata;
                    bfd_pkg::CFG_DEDUP_ENABLE:   dedup_en_reg <= cfg_wdata[0];
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        req_reg      <= bfd_pkg::req_t'(s_tuser[bfd_pkg::REQ_BITS-1:0]);
                        has_hash_reg <= s_tuser[bfd_pkg::REQ_BITS];
                        tag_reg      <= s_tdata[TAG_BITS-1:0];
                        key_reg      <= s_tdata[TAG_BITS +: KB];
                        marker_reg   <= s_tdata[TAG_BITS + KB +: KB];
                        state_reg    <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    // The head entry was read at acceptance; a pop takes its fields and,
                    // for the table walk, its hash.
                    if ((req_reg == bfd_pkg::REQ_POP) && pop_ok)
                    begin
                        res_tag_reg  <= rd_tag;
                        res_size_reg <= rd_size;
                        key_reg      <= rd_hash;
                    end
                    else
                    begin
                        res_tag_reg  <= '0;
                        res_size_reg <= '0;
                    end
                    if (start_scan)
                    begin
                        scan_ptr_reg   <= '0;
                        cmp_valid_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        state_reg      <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    // Each address goes out in the cycle before its compare.
                    if (scan_issue)
                    begin
                        scan_ptr_reg <= scan_ptr_reg + 1'b1;
                    end
                    cmp_valid_reg <= scan_issue;
                    cmp_idx_reg   <= scan_ptr_reg[AW-1:0];
                    if (cmp_valid_reg && !tbl_rd_valid && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= cmp_idx_reg;
                    end
                end
                ST_RESULT:
                begin
                    if (out_free)
                    begin
                        out_status_reg <= res_status_reg;
                        out_tag_reg    <= res_tag_reg;
                        out_size_reg   <= res_size_reg;
                        out_occ_reg    <= bfd_pkg::OCC_BITS'(count_reg);
                        state_reg      <= ST_IDLE;
                    end
                end
            endcase

            if (fin)
            begin
                res_status_reg <= fin_status;
                state_reg      <= ST_RESULT;
            end

            if (enq)
            begin
                tail_reg  <= (tail_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                count_reg <= count_reg + 1'b1;
            end
            if (deq)
            begin
                head_reg  <= (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                count_reg <= count_reg - 1'b1;
            end
            if (tbl_cmd.flush)
            begin
                head_reg  <= '0;
                tail_reg  <= '0;
                count_reg <= '0;
                shut_reg  <= (req_reg == bfd_pkg::REQ_STOP);
            end

            if ((state_reg == ST_RESULT) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Queue memory; the head slot is read every cycle.
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            fifo_mem[tail_reg] <= {bfd_pkg::SIZE_BITS'(count_reg), has_hash_reg,
                                   key_reg, tag_reg};
        end
        fifo_rd_reg <= fifo_mem[head_reg];
    end

    bfd_dedup_table #(
        .DEPTH (QUEUE_DEPTH)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_idx    (scan_ptr_reg[AW-1:0]),
        .cmd       (tbl_cmd),
        .wr_idx    (tbl_wr_idx),
        .wr_key    (key_reg),
        .wr_marker (marker_reg),
        .rd_valid  (tbl_rd_valid),
        .rd_key    (tbl_rd_key),
        .rd_marker (tbl_rd_marker)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = MDW'({out_occ_reg, out_size_reg, out_tag_reg});

    // The occupancy never passes the physical depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");

    // An enqueue only happens below the effective capacity.
    a_enq_room: assert property (@(posedge clk) disable iff (!rst_n)
        enq |-> !cap_hit)
        else $error("enqueue into a full queue");

    // A dequeue only happens on a non-empty queue that is not shut down.
    a_deq_data: assert property (@(posedge clk) disable iff (!rst_n)
        deq |-> pop_ok)
        else $error("dequeue from an empty or shut queue");

    // An accepted request always moves the sequencer to execution.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted request not executed");

    // A finished result reaches the output register once it is free.
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RESULT) && out_free) |=> (m_tvalid_reg && (state_reg == ST_IDLE)))
        else $error("result not delivered");

endmodule
